// File: rtl/cds_pkg.sv
package cds_pkg;

  localparam int QUEUE_DEPTH_DEF = 32;
  localparam int CYL_BITS_DEF    = 16;

  // Fixed field widths of the stream and configuration ports.
  localparam int CYL_W       = 16;
  localparam int CNT_W       = 17;
  localparam int SEEK_W      = 22;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 56;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 17;

  localparam logic [CFG_IDX_W-1:0] REG_CYL_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_HEAD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION  = 2'd2;

  localparam logic [CNT_W-1:0] CYL_COUNT_RST = 17'd200;

  // One request to the seek accumulator to emit a visited position.
  typedef struct packed {
    logic valid;
    logic first;
    logic final_res;
  } put_req_t;

endpackage

// File: rtl/cds_seek_acc.sv
module cds_seek_acc #(
  parameter int VW = cds_pkg::CNT_W
) (
  input  logic                           clk,
  input  logic                           rst,
  input  cds_pkg::put_req_t              put,
  input  logic [VW-1:0]                  pos,
  output logic                           put_ready,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // position [15:0], step_distance [31:16], total_seek [53:32], zero fill
  output logic [cds_pkg::OUT_TDATA_W-1:0] m_tdata,
  // final_res
  output logic                           m_tlast
);
  import cds_pkg::*;

  logic [VW-1:0]     prev;
  logic [SEEK_W-1:0] seek;
  logic [CYL_W-1:0]  pos_q;
  logic [CYL_W-1:0]  dist_q;
  logic [VW-1:0]     delta;
  logic [SEEK_W-1:0] seek_next;

  assign put_ready = !m_tvalid || m_tready;

  always_comb begin
    if (put.first) begin
      delta     = '0;
      seek_next = '0;
    end else begin
      delta     = (pos >= prev) ? pos - prev : prev - pos;
      seek_next = seek + SEEK_W'(delta);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      seek     <= '0;
      prev     <= '0;
    end else begin
      if (put.valid && put_ready) begin
        m_tvalid <= 1'b1;
        seek     <= seek_next;
        prev     <= pos;
        pos_q    <= pos[CYL_W-1:0];
        dist_q   <= delta[CYL_W-1:0];
        m_tlast  <= put.final_res;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {{(OUT_TDATA_W - SEEK_W - 2 * CYL_W){1'b0}}, seek, dist_q, pos_q};

endmodule

// File: rtl/cscan_disk_scheduler.sv
// Requests are taken one per cycle while loading; a transfer marked tlast
// closes the batch. Ranking the n stored requests then uses one memory read
// per comparison, and each of the n + 3 results passes through a read of the
// sorted memory, then the output register.
// Synchronous reset loads the configuration defaults and clears the request count
// and seek total; the request memories are not cleared.
module cscan_disk_scheduler #(
  parameter int QUEUE_DEPTH   = cds_pkg::QUEUE_DEPTH_DEF,
  parameter int CYLINDER_BITS = cds_pkg::CYL_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // cylinder [15:0]
  input  logic [cds_pkg::IN_TDATA_W-1:0]  s_tdata,
  // last
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // position [15:0], step_distance [31:16], total_seek [53:32], zero fill
  output logic [cds_pkg::OUT_TDATA_W-1:0] m_tdata,
  // final_res
  output logic                            m_tlast,
  input  logic                            cfg_we,
  input  logic [cds_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cds_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import cds_pkg::*;

  localparam int SW = (CYLINDER_BITS < CYL_W) ? CYLINDER_BITS : CYL_W;
  localparam int VW = (CYLINDER_BITS > CNT_W) ? CYLINDER_BITS : CNT_W;
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int KW = $clog2(QUEUE_DEPTH + 3);
  localparam int EW = KW + 1;
  localparam logic [VW:0] CAP_MAX = (VW+1)'(1) << CYLINDER_BITS;

  typedef enum logic [2:0] {
    ST_LOAD, ST_RANK_OUT, ST_RANK_HOLD, ST_RANK_IN, ST_RANK_WR, ST_EMIT_RD, ST_EMIT_PUT
  } state_t;

  typedef enum logic [1:0] {SLOT_HEAD, SLOT_MEM, SLOT_TOP, SLOT_ZERO} slot_t;

  function automatic logic [VW-1:0] clamp(input logic [SW-1:0] v, input logic [VW-1:0] t);
    logic [VW-1:0] w;
    w = VW'(v);
    return (w > t) ? t : w;
  endfunction

  // Configuration registers.
  logic [CNT_W-1:0] cyl_count;
  logic [CYL_W-1:0] start_head;
  logic             direction;

  always_ff @(posedge clk) begin
    if (rst) begin
      cyl_count  <= CYL_COUNT_RST;
      start_head <= '0;
      direction  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CYL_COUNT:  cyl_count  <= cfg_data;
        REG_START_HEAD: start_head <= cfg_data[CYL_W-1:0];
        REG_DIRECTION:  direction  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sweep end and head position, clamped to the cylinder range.
  logic [VW:0]   cap_ext;
  logic [VW:0]   cap;
  logic [VW-1:0] top;
  logic [VW-1:0] head;

  assign cap_ext = (VW+1)'(cyl_count);
  assign cap     = (cap_ext == '0) ? (VW+1)'(1) : ((cap_ext > CAP_MAX) ? CAP_MAX : cap_ext);
  assign top     = VW'(cap - (VW+1)'(1));
  assign head    = (VW'(start_head) > top) ? top : VW'(start_head);

  state_t         state;
  logic [CW-1:0]  count;
  logic [AW-1:0]  i_idx;
  logic [AW-1:0]  j_rd;
  logic [AW-1:0]  rank;
  logic [SW-1:0]  vi;
  logic [CW-1:0]  lo;
  logic [KW-1:0]  k;

  // Raw requests in arrival order, and the same requests in ascending order.
  logic [SW-1:0] raw_mem [QUEUE_DEPTH];
  logic [SW-1:0] raw_rdata;
  logic [AW-1:0] raw_raddr;
  logic          raw_we;
  logic [SW-1:0] sorted_mem [QUEUE_DEPTH];
  logic [SW-1:0] sorted_rdata;
  logic [AW-1:0] emit_addr;

  assign s_tready = (state == ST_LOAD);
  assign raw_we   = s_tvalid && s_tready && (count < CW'(QUEUE_DEPTH));

  always_comb begin
    unique case (state)
      ST_RANK_OUT:  raw_raddr = i_idx;
      ST_RANK_HOLD: raw_raddr = '0;
      default:      raw_raddr = j_rd + AW'(1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (raw_we) begin
      raw_mem[count[AW-1:0]] <= s_tdata[SW-1:0];
    end
    raw_rdata <= raw_mem[raw_raddr];
  end

  always_ff @(posedge clk) begin
    if (state == ST_RANK_WR) begin
      sorted_mem[rank] <= vi;
    end
    sorted_rdata <= sorted_mem[emit_addr];
  end

  // A stable rank: smaller values first, equal values in arrival order.
  logic rank_inc;
  assign rank_inc = (raw_rdata < vi) || ((raw_rdata == vi) && (j_rd < i_idx));

  // Service order slot k: lo requests lie at or below the head, hi above it.
  slot_t         slot;
  logic          slot_final;
  logic [VW-1:0] slot_pos;

  always_comb begin
    logic [EW-1:0] ek;
    logic [EW-1:0] elo;
    logic [EW-1:0] en;
    logic [EW-1:0] ehi;
    logic [EW-1:0] addr;
    ek   = EW'(k);
    elo  = EW'(lo);
    en   = EW'(count);
    ehi  = en - elo;
    addr = '0;
    if (k == '0) begin
      slot = SLOT_HEAD;
    end else if (!direction) begin
      if (ek <= ehi) begin
        slot = SLOT_MEM;
        addr = elo + ek - EW'(1);
      end else if (ek == ehi + EW'(1)) begin
        slot = SLOT_TOP;
      end else if (ek == ehi + EW'(2)) begin
        slot = SLOT_ZERO;
      end else begin
        slot = SLOT_MEM;
        addr = ek - ehi - EW'(3);
      end
    end else begin
      if (ek <= elo) begin
        slot = SLOT_MEM;
        addr = elo - ek;
      end else if (ek == elo + EW'(1)) begin
        slot = SLOT_ZERO;
      end else if (ek == elo + EW'(2)) begin
        slot = SLOT_TOP;
      end else begin
        slot = SLOT_MEM;
        addr = en + elo + EW'(2) - ek;
      end
    end
    emit_addr  = addr[AW-1:0];
    slot_final = (ek == en + EW'(2));
    unique case (slot)
      SLOT_HEAD: slot_pos = head;
      SLOT_MEM:  slot_pos = clamp(sorted_rdata, top);
      SLOT_TOP:  slot_pos = top;
      default:   slot_pos = '0;
    endcase
  end

  put_req_t put;
  logic     put_ready;

  assign put.valid     = (state == ST_EMIT_PUT);
  assign put.first     = (k == '0);
  assign put.final_res = slot_final;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      count <= '0;
      i_idx <= '0;
      j_rd  <= '0;
      rank  <= '0;
      lo    <= '0;
      k     <= '0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (s_tvalid) begin
            if (raw_we) begin
              count <= count + CW'(1);
            end
            if (s_tlast) begin
              i_idx <= '0;
              lo    <= '0;
              state <= ST_RANK_OUT;
            end
          end
        end
        ST_RANK_OUT: begin
          state <= ST_RANK_HOLD;
        end
        ST_RANK_HOLD: begin
          vi    <= raw_rdata;
          rank  <= '0;
          j_rd  <= '0;
          if (clamp(raw_rdata, top) <= head) begin
            lo <= lo + CW'(1);
          end
          state <= ST_RANK_IN;
        end
        ST_RANK_IN: begin
          rank <= rank + AW'(rank_inc);
          if (CW'(j_rd) == count - CW'(1)) begin
            state <= ST_RANK_WR;
          end else begin
            j_rd <= j_rd + AW'(1);
          end
        end
        ST_RANK_WR: begin
          if (CW'(i_idx) == count - CW'(1)) begin
            k     <= '0;
            state <= ST_EMIT_RD;
          end else begin
            i_idx <= i_idx + AW'(1);
            state <= ST_RANK_OUT;
          end
        end
        ST_EMIT_RD: begin
          state <= ST_EMIT_PUT;
        end
        ST_EMIT_PUT: begin
          if (put_ready) begin
            if (slot_final) begin
              count <= '0;
              state <= ST_LOAD;
            end else begin
              k     <= k + KW'(1);
              state <= ST_EMIT_RD;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  cds_seek_acc #(
    .VW(VW)
  ) u_seek_acc (
    .clk       (clk),
    .rst       (rst),
    .put       (put),
    .pos       (slot_pos),
    .put_ready (put_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule
